// ===== src/stpm_pkg.sv =====
// stpm_pkg: shared types and constants for the stereo timestamp pair matcher
// no dependencies

package stpm_pkg;

    localparam int TIME_W = 48;
    localparam int TAG_W  = 16;

    localparam logic [1:0] OP_PUSH_VIS = 2'd0;
    localparam logic [1:0] OP_PUSH_IR  = 2'd1;
    localparam logic [1:0] OP_SYNC     = 2'd2;

    localparam logic REG_DIFF_WIN = 1'b0;
    localparam logic REG_LIMIT    = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] timestamp;
        logic [TAG_W-1:0]  frame_tag;
    } t_in_item;

    typedef struct packed {
        logic              paired;
        logic [TAG_W-1:0]  visible_tag;
        logic [TAG_W-1:0]  infrared_tag;
        logic [TIME_W-1:0] pair_time;
        logic [31:0]       dropped_total;
        logic [31:0]       paired_total;
    } t_out_item;

endpackage

// ===== src/stpm_diff_unit.sv =====
// stpm_diff_unit: shared absolute-difference and compare unit
// depends on stpm_pkg

module stpm_diff_unit (
    input  logic [stpm_pkg::TIME_W-1:0] i_a,
    input  logic [stpm_pkg::TIME_W-1:0] i_b,
    input  logic [stpm_pkg::TIME_W-1:0] i_best,
    output logic [stpm_pkg::TIME_W-1:0] o_diff,
    output logic                        o_less,
    output logic                        o_a_older
);
    import stpm_pkg::*;

    // absolute difference, then compare against current best
    always_comb begin
        o_a_older = i_a < i_b;
        o_diff    = o_a_older ? (i_b - i_a) : (i_a - i_b);
        o_less    = o_diff < i_best;
    end
endmodule

// ===== src/stereo_timestamp_pair_matcher_top.sv =====
// stereo_timestamp_pair_matcher_top: sequencer, frame fifos and counters
// depends on stpm_pkg and stpm_diff_unit
//
// Usage: pulse i_start with an item on i_in while o_busy is low. Ops 0 and 1
// push a frame into the visible or infrared fifo and produce no result. Op 2
// is a sync attempt: the sequencer walks every visible/infrared pair, one
// pair per cycle through a single difference/compare unit, then pairs or drops.
// A sync item gives exactly one result on o_out, marked by o_valid for one
// cycle. The receiver cannot stall; results must be taken when shown.
// A push passes through the shift and write states. A sync passes through
// the scan, decide, shift and done states, or goes straight to done when a
// fifo is empty; both fifos shift one entry per cycle in parallel. The
// result strobes in the same cycle that o_busy falls.
// Reset clears counts, counters and configuration registers to their defaults
// (max difference 20000, queue limit 10); fifo contents are not cleared.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data while idle.

module stereo_timestamp_pair_matcher_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  stpm_pkg::t_in_item  i_in,
    output logic                o_busy,
    output logic                o_valid,
    output stpm_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import stpm_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_PUSHW = 3'd5;

    logic [TIME_W-1:0] r_vts  [FIFO_DEPTH];
    logic [TAG_W-1:0]  r_vtag [FIFO_DEPTH];
    logic [TIME_W-1:0] r_its  [FIFO_DEPTH];
    logic [TAG_W-1:0]  r_itag [FIFO_DEPTH];

    logic [2:0]        r_state;
    logic [CW-1:0]     r_vcnt, r_icnt;
    logic [31:0]       r_drops, r_pairs, r_diff_win;
    logic [4:0]        r_limit;
    logic [IW-1:0]     r_i, r_j, r_bi, r_bj;
    logic [TIME_W-1:0] r_best;
    logic              r_found;
    logic [CW-1:0]     r_vpop, r_ipop;
    logic              r_valid;
    t_out_item         r_out;
    t_in_item          r_pend;
    logic              r_out_pend;

    logic [TIME_W-1:0] diff;
    logic              less, v_older;
    logic [TIME_W-1:0] ua, ub;
    logic [CW-1:0]     lim;
    logic              v_end, i_end;

    // effective limit: 0 acts as 1, clipped to depth
    always_comb begin
        if (r_limit == 5'd0) lim = CW'(1);
        else if (32'(r_limit) > 32'(FIFO_DEPTH)) lim = CW'(FIFO_DEPTH);
        else lim = CW'(r_limit);
    end

    // shared unit operands: scan pair, or the fronts in decide
    assign ua = (r_state == S_SCAN) ? r_vts[r_i] : r_vts[0];
    assign ub = (r_state == S_SCAN) ? r_its[r_j] : r_its[0];

    stpm_diff_unit u_diff (
        .i_a(ua), .i_b(ub), .i_best(r_best),
        .o_diff(diff), .o_less(less), .o_a_older(v_older)
    );

    assign v_end = (CW'(r_i) + CW'(1)) >= r_vcnt;
    assign i_end = (CW'(r_j) + CW'(1)) >= r_icnt;

    // saturating add helper
    function automatic logic [31:0] sat_add(logic [31:0] a, logic [32:0] b);
        logic [33:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > 34'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_win <= 32'd20000;
            r_limit    <= 5'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIFF_WIN: r_diff_win <= i_cfg_data;
                REG_LIMIT:    r_limit    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_icnt  <= '0;
            r_drops <= '0;
            r_pairs <= '0;
            r_valid <= 1'b0;
            r_vpop  <= '0;
            r_ipop  <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_in.op == OP_PUSH_VIS) begin
                            r_vpop  <= (r_vcnt >= lim && r_vcnt != '0) ? CW'(1) : '0;
                            r_ipop  <= '0;
                            r_state <= S_SHIFT;
                            if (r_vcnt >= lim && r_vcnt != '0)
                                r_drops <= sat_add(r_drops, 33'd1);
                        end else if (i_in.op == OP_PUSH_IR) begin
                            r_ipop  <= (r_icnt >= lim && r_icnt != '0) ? CW'(1) : '0;
                            r_vpop  <= '0;
                            r_state <= S_SHIFT;
                            if (r_icnt >= lim && r_icnt != '0)
                                r_drops <= sat_add(r_drops, 33'd1);
                        end else if (i_in.op == OP_SYNC) begin
                            r_i <= '0; r_j <= '0; r_bi <= '0; r_bj <= '0;
                            r_found <= 1'b0;
                            r_best  <= '0;
                            r_vpop  <= '0;
                            r_ipop  <= '0;
                            if (r_vcnt == '0 || r_icnt == '0) r_state <= S_DONE;
                            else r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_found || less) begin
                        r_found <= 1'b1;
                        r_best  <= diff;
                        r_bi    <= r_i;
                        r_bj    <= r_j;
                    end
                    if (i_end) begin
                        r_j <= '0;
                        if (v_end) r_state <= S_DEC;
                        else r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_DEC: begin
                    if (r_best > TIME_W'(r_diff_win)) begin
                        if (r_vcnt > (lim >> 1) && v_older) begin
                            r_vpop  <= CW'(1);
                            r_drops <= sat_add(r_drops, 33'd1);
                        end else if (r_icnt > (lim >> 1) && r_its[0] < r_vts[0]) begin
                            r_ipop  <= CW'(1);
                            r_drops <= sat_add(r_drops, 33'd1);
                        end
                    end else begin
                        r_vpop  <= CW'(r_bi) + CW'(1);
                        r_ipop  <= CW'(r_bj) + CW'(1);
                        r_drops <= sat_add(r_drops, 33'(r_bi) + 33'(r_bj));
                        if (r_pairs != 32'hFFFFFFFF) r_pairs <= r_pairs + 32'd1;
                    end
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    // shift one entry per cycle off each front
                    if (r_vpop != '0) begin
                        r_vpop <= r_vpop - CW'(1);
                        r_vcnt <= r_vcnt - CW'(1);
                    end
                    if (r_ipop != '0) begin
                        r_ipop <= r_ipop - CW'(1);
                        r_icnt <= r_icnt - CW'(1);
                    end
                    if (r_vpop <= CW'(1) && r_ipop <= CW'(1)) begin
                        if (r_out_pend) r_state <= S_DONE;
                        else r_state <= S_PUSHW;
                    end
                end
                S_PUSHW: begin
                    if (r_pend.op == OP_PUSH_VIS) begin
                        if (r_vcnt < CW'(FIFO_DEPTH)) r_vcnt <= r_vcnt + CW'(1);
                    end else begin
                        if (r_icnt < CW'(FIFO_DEPTH)) r_icnt <= r_icnt + CW'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pending item and result capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pend <= 1'b0;
        end else if (r_state == S_IDLE && i_start) begin
            r_out_pend <= (i_in.op == OP_SYNC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_pend <= i_in;
            r_out  <= '0;
        end
        if (r_state == S_DEC) begin
            if (r_best <= TIME_W'(r_diff_win)) begin
                r_out.paired       <= 1'b1;
                r_out.visible_tag  <= r_vtag[r_bi];
                r_out.infrared_tag <= r_itag[r_bj];
                r_out.pair_time    <= TIME_W'(({1'b0, r_vts[r_bi]} + {1'b0, r_its[r_bj]}) >> 1);
            end
        end
        if (r_state == S_DONE) begin
            r_out.dropped_total <= r_drops;
            r_out.paired_total  <= r_pairs;
        end
    end

    // fifo storage: shift toward front, write at tail
    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT) begin
            for (int k = 0; k < FIFO_DEPTH - 1; k++) begin
                if (r_vpop != '0) begin
                    r_vts[k]  <= r_vts[k+1];
                    r_vtag[k] <= r_vtag[k+1];
                end
                if (r_ipop != '0) begin
                    r_its[k]  <= r_its[k+1];
                    r_itag[k] <= r_itag[k+1];
                end
            end
        end
        if (r_state == S_PUSHW) begin
            if (r_pend.op == OP_PUSH_VIS && r_vcnt < CW'(FIFO_DEPTH)) begin
                r_vts[r_vcnt[IW-1:0]]  <= r_pend.timestamp;
                r_vtag[r_vcnt[IW-1:0]] <= r_pend.frame_tag;
            end
            if (r_pend.op == OP_PUSH_IR && r_icnt < CW'(FIFO_DEPTH)) begin
                r_its[r_icnt[IW-1:0]]  <= r_pend.timestamp;
                r_itag[r_icnt[IW-1:0]] <= r_pend.frame_tag;
            end
        end
    end

    // result strobed in the cycle after done
    always_comb begin
        o_busy  = (r_state != S_IDLE);
        o_valid = r_valid;
        o_out   = r_out;
    end
endmodule

// ===== test/stereo_timestamp_pair_matcher_top_tb.sv =====
// stereo_timestamp_pair_matcher_top_tb: self-checking bench for the pair matcher
// predicts sync results in-bench and compares every strobed result in order
// depends on stpm_pkg and stereo_timestamp_pair_matcher_top

module stereo_timestamp_pair_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stpm_pkg::*;

    localparam int DEPTH     = 16;
    localparam int IDLE_MAX  = 20000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_in_item    i_in;
    logic        o_busy;
    logic        o_valid;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    stereo_timestamp_pair_matcher_top #(.FIFO_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_in(i_in),
        .o_busy(o_busy), .o_valid(o_valid), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predicted block state
    logic [TIME_W-1:0] vis_ts [DEPTH];
    logic [TAG_W-1:0]  vis_tag[DEPTH];
    logic [TIME_W-1:0] ir_ts  [DEPTH];
    logic [TAG_W-1:0]  ir_tag [DEPTH];
    int unsigned       vis_cnt, ir_cnt;
    logic [31:0]       drops, pairs;
    logic [31:0]       diff_win;
    logic [4:0]        qlimit;

    t_out_item   sync_results[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned burst_left;
    logic [TIME_W-1:0] frame_time;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_limit();
        int unsigned l;
        l = qlimit;
        if (l == 0) l = 1;
        if (l > DEPTH) l = DEPTH;
        return l;
    endfunction

    function automatic void add_drops(int unsigned n);
        longint unsigned s;
        s = longint'(drops) + n;
        drops = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void pop_vis(int unsigned n);
        if (n > vis_cnt) n = vis_cnt;
        for (int k = 0; k + n < vis_cnt; k++) begin
            vis_ts[k]  = vis_ts[k+n];
            vis_tag[k] = vis_tag[k+n];
        end
        vis_cnt -= n;
    endfunction

    function automatic void pop_ir(int unsigned n);
        if (n > ir_cnt) n = ir_cnt;
        for (int k = 0; k + n < ir_cnt; k++) begin
            ir_ts[k]  = ir_ts[k+n];
            ir_tag[k] = ir_tag[k+n];
        end
        ir_cnt -= n;
    endfunction

    // apply one accepted item to the predicted state, queue any result
    function automatic void predict_item(t_in_item it);
        t_out_item r;
        logic [TIME_W:0] d, best, total;
        int unsigned bi, bj, half;
        bit found;
        found = 0;
        best = '0;
        bi = 0;
        bj = 0;
        r = '0;
        case (it.op)
            OP_PUSH_VIS: begin
                if (vis_cnt >= active_limit() && vis_cnt > 0) begin
                    pop_vis(1);
                    add_drops(1);
                end
                vis_ts[vis_cnt]  = it.timestamp;
                vis_tag[vis_cnt] = it.frame_tag;
                vis_cnt++;
            end
            OP_PUSH_IR: begin
                if (ir_cnt >= active_limit() && ir_cnt > 0) begin
                    pop_ir(1);
                    add_drops(1);
                end
                ir_ts[ir_cnt]  = it.timestamp;
                ir_tag[ir_cnt] = it.frame_tag;
                ir_cnt++;
            end
            OP_SYNC: begin
                for (int i = 0; i < vis_cnt; i++) begin
                    for (int j = 0; j < ir_cnt; j++) begin
                        d = (vis_ts[i] > ir_ts[j]) ? vis_ts[i] - ir_ts[j]
                                                   : ir_ts[j] - vis_ts[i];
                        if (!found || d < best) begin
                            found = 1;
                            best = d;
                            bi = i;
                            bj = j;
                        end
                    end
                end
                if (found) begin
                    if (best > {17'd0, diff_win}) begin
                        half = active_limit() / 2;
                        if (vis_cnt > half && vis_ts[0] < ir_ts[0]) begin
                            pop_vis(1);
                            add_drops(1);
                        end else if (ir_cnt > half && ir_ts[0] < vis_ts[0]) begin
                            pop_ir(1);
                            add_drops(1);
                        end
                    end else begin
                        r.paired       = 1'b1;
                        r.visible_tag  = vis_tag[bi];
                        r.infrared_tag = ir_tag[bj];
                        total = {1'b0, vis_ts[bi]} + {1'b0, ir_ts[bj]};
                        r.pair_time    = total[TIME_W:1];
                        add_drops(bi + bj);
                        pop_vis(bi + 1);
                        pop_ir(bj + 1);
                        if (pairs != 32'hFFFF_FFFF) pairs++;
                    end
                end
                r.dropped_total = drops;
                r.paired_total  = pairs;
                sync_results.insert(sync_results.size(), r);
            end
            default: ;
        endcase
    endfunction

    // send one item; bursts with random gaps between them
    task automatic send_item(t_in_item it);
        int unsigned gap;
        i_start <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_busy);
        predict_item(it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_op(logic [1:0] op, logic [TIME_W-1:0] ts, logic [TAG_W-1:0] tag);
        t_in_item it;
        it.op = op;
        it.timestamp = ts;
        it.frame_tag = tag;
        send_item(it);
    endtask

    // hold off until the block is idle with nothing outstanding
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sync_results.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_DIFF_WIN) diff_win = data;
        else qlimit = data[4:0];
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (sync_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out);
            end else begin
                want = sync_results[0];
                sync_results.delete(0);
                if (want.paired !== o_out.paired || want.visible_tag !== o_out.visible_tag
                    || want.infrared_tag !== o_out.infrared_tag
                    || want.pair_time !== o_out.pair_time
                    || want.dropped_total !== o_out.dropped_total
                    || want.paired_total !== o_out.paired_total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, o_out);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // extremes, ties, empty sync and the unused op
    task automatic test_directed();
        send_op(OP_SYNC, '0, '0);
        send_op(OP_PUSH_VIS, '0, 16'hFFFF);
        send_op(OP_SYNC, '1, '0);
        send_op(OP_PUSH_IR, '1, 16'h0000);
        send_op(OP_SYNC, '0, '0);
        send_op(OP_PUSH_VIS, '1, 16'h1234);
        send_op(OP_SYNC, '0, '0);
        send_op(OP_NONE, '1, '1);
        send_op(OP_PUSH_VIS, 48'd1000, 16'hA001);
        send_op(OP_PUSH_IR, 48'd990, 16'hB001);
        send_op(OP_PUSH_IR, 48'd1010, 16'hB002);
        send_op(OP_SYNC, '0, '0);
        send_op(OP_SYNC, '0, '0);
        send_op(OP_SYNC, '0, '0);
    endtask

    // register extremes: tight and wide window, limit zero, above depth, lowered
    task automatic test_limits();
        write_reg(REG_DIFF_WIN, 32'd0);
        write_reg(REG_LIMIT, 32'd0);
        send_op(OP_PUSH_VIS, 48'd50, 16'h0001);
        send_op(OP_PUSH_VIS, 48'd60, 16'h0002);
        send_op(OP_PUSH_IR, 48'd60, 16'h0003);
        send_op(OP_SYNC, '0, '0);
        write_reg(REG_LIMIT, 32'd31);
        for (int k = 0; k < 18; k++) send_op(OP_PUSH_VIS, 48'(k * 7), 16'(k));
        send_op(OP_PUSH_IR, 48'd5000, 16'h00EE);
        send_op(OP_SYNC, '0, '0);
        write_reg(REG_LIMIT, 32'd3);
        send_op(OP_PUSH_VIS, 48'd9000, 16'h0101);
        send_op(OP_PUSH_VIS, 48'd9001, 16'h0102);
        write_reg(REG_DIFF_WIN, 32'hFFFF_FFFF);
        send_op(OP_SYNC, '0, '0);
        write_reg(REG_LIMIT, 32'd16);
    endtask

    // random traffic, mostly frame-rate streams with jitter, some noise
    task automatic test_random(int unsigned n);
        t_in_item it;
        int unsigned sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            it.frame_tag = 16'($urandom);
            it.timestamp = frame_time + $urandom_range(0, 4000);
            if (sel < 35) it.op = OP_PUSH_VIS;
            else if (sel < 70) it.op = OP_PUSH_IR;
            else if (sel < 92) it.op = OP_SYNC;
            else if (sel < 96) begin
                it.op = 2'($urandom_range(0, 1));
                it.timestamp = {16'($urandom), 32'($urandom)};
            end else it.op = OP_NONE;
            if ($urandom_range(0, 2) == 0) frame_time += $urandom_range(10000, 40000);
            if (k == n / 2) drain();
            send_item(it);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_DIFF_WIN;
        i_cfg_data = '0;
        vis_cnt = 0;
        ir_cnt = 0;
        drops = '0;
        pairs = '0;
        diff_win = 32'd20000;
        qlimit = 5'd10;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        frame_time = 48'd1000000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        frame_time = {16'h0, 32'($urandom)};
        test_random(260);
        write_reg(REG_DIFF_WIN, 32'd2000);
        write_reg(REG_LIMIT, 32'd4);
        test_random(260);
        write_reg(REG_DIFF_WIN, 32'd50000);
        write_reg(REG_LIMIT, 32'd1);
        test_random(240);
        write_reg(REG_DIFF_WIN, 32'd20000);
        write_reg(REG_LIMIT, 32'd10);
        test_random(240);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && sync_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/stpm_pkg.sv
src/stpm_diff_unit.sv
src/stereo_timestamp_pair_matcher_top.sv
test/stereo_timestamp_pair_matcher_top_tb.sv
